// ===== src/line_assembler_with_overflow_discard_defines.svh =====
// Assertion macros for the line assembler.
`ifndef LINE_ASSEMBLER_WITH_OVERFLOW_DISCARD_DEFINES_SVH
`define LINE_ASSEMBLER_WITH_OVERFLOW_DISCARD_DEFINES_SVH

`ifndef SYNTH
`define LAFD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lafd: implication check failed");
`define LAFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lafd: next-cycle check failed");
`else
`define LAFD_ASSERT_IMP(label, ante, cons)
`define LAFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/lafd_pkg.sv =====
`timescale 1ns / 1ps
package lafd_pkg;

  localparam int LINE_MAX = 64;
  localparam int FILL_W   = $clog2(LINE_MAX);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(LINE_MAX - 1);

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_LINE  = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;
  localparam logic [1:0] OP_OVF   = 2'd3;

  // queue depth, power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        data;        // byte to store
    logic [FILL_W-1:0] addr;        // store address, or line length
    logic [31:0]       line_total;
    logic [31:0]       ovf_total;
  } cmd_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// ===== src/lafd_ram.sv =====
`timescale 1ns / 1ps
module lafd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/lafd_front.sv =====
`timescale 1ns / 1ps
module lafd_front import lafd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  logic [FILL_W-1:0] fill, fill_next;
  logic              discard, discard_next;
  logic [31:0]       line_cnt, line_cnt_next;
  logic [31:0]       ovf_cnt, ovf_cnt_next;
  logic              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    fill_next     = fill;
    discard_next  = discard;
    line_cnt_next = line_cnt;
    ovf_cnt_next  = ovf_cnt;
    push          = 1'b0;
    cmd.op        = OP_STORE;
    cmd.data      = rx_byte;
    cmd.addr      = fill;
    if (accept) begin
      if (rx_byte == CH_NL) begin
        fill_next = '0;
        if (discard) begin
          discard_next = 1'b0;
        end else begin
          line_cnt_next = sat_inc(line_cnt);
          push          = 1'b1;
          cmd.op        = (fill == '0) ? OP_EMPTY : OP_LINE;
        end
      end else if (rx_byte != CH_CR && !discard) begin
        push = 1'b1;
        if (fill != FILL_LAST) begin
          fill_next = fill + 1'b1;
        end else begin
          // store full: drop the partial line and skip to next newline
          fill_next    = '0;
          discard_next = 1'b1;
          ovf_cnt_next = sat_inc(ovf_cnt);
          cmd.op       = OP_OVF;
        end
      end
    end
    cmd.line_total = line_cnt_next;
    cmd.ovf_total  = ovf_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      discard  <= 1'b0;
      line_cnt <= '0;
      ovf_cnt  <= '0;
    end else begin
      fill     <= fill_next;
      discard  <= discard_next;
      line_cnt <= line_cnt_next;
      ovf_cnt  <= ovf_cnt_next;
    end
  end

endmodule

// ===== src/lafd_queue.sv =====
`timescale 1ns / 1ps
module lafd_queue import lafd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t            entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full       = (count == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/lafd_back.sv =====
`timescale 1ns / 1ps
module lafd_back import lafd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [7:0]  line_char,
  output logic        run_last,
  output logic [31:0] line_total,
  output logic [31:0] overflow_total
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic              state, state_next;
  logic [FILL_W-1:0] idx, idx_next;
  logic [FILL_W-1:0] len, len_next;
  logic [31:0]       cur_line, cur_line_next;
  logic [31:0]       cur_ovf, cur_ovf_next;

  logic              out_free;
  logic              load;
  logic [1:0]        ld_kind;
  logic [7:0]        ld_char;
  logic              ld_last;
  logic [31:0]       ld_line;
  logic [31:0]       ld_ovf;
  logic              last_char;

  logic              ram_we;
  logic [FILL_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  lafd_ram #(
    .WIDTH (8),
    .DEPTH (LINE_MAX)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (q_head.addr),
    .wr_data (q_head.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free  = !out_valid || !out_stall;
  assign last_char = (idx == len - 1'b1);
  assign ram_we    = q_pop && (q_head.op == OP_STORE);

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    len_next      = len;
    cur_line_next = cur_line;
    cur_ovf_next  = cur_ovf;
    q_pop         = 1'b0;
    load          = 1'b0;
    ld_kind       = KIND_CHAR;
    ld_char       = 8'd0;
    ld_last       = 1'b1;
    ld_line       = q_head.line_total;
    ld_ovf        = q_head.ovf_total;
    rd_addr       = '0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_head.op)
            OP_STORE: begin
              q_pop = 1'b1;
            end
            OP_LINE: begin
              if (out_free) begin
                // first read (address zero) goes out this cycle
                q_pop         = 1'b1;
                idx_next      = '0;
                len_next      = q_head.addr;
                cur_line_next = q_head.line_total;
                cur_ovf_next  = q_head.ovf_total;
                state_next    = ST_DRAIN;
              end
            end
            OP_EMPTY: begin
              if (out_free) begin
                q_pop   = 1'b1;
                load    = 1'b1;
                ld_kind = KIND_EMPTY;
              end
            end
            OP_OVF: begin
              if (out_free) begin
                q_pop   = 1'b1;
                load    = 1'b1;
                ld_kind = KIND_OVERFLOW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        ld_line = cur_line;
        ld_ovf  = cur_ovf;
        rd_addr = idx;
        if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_CHAR;
          ld_char = rd_data;
          ld_last = last_char;
          if (last_char) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            rd_addr  = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    len      <= len_next;
    cur_line <= cur_line_next;
    cur_ovf  <= cur_ovf_next;
    if (load) begin
      event_kind     <= ld_kind;
      line_char      <= ld_char;
      run_last       <= ld_last;
      line_total     <= ld_line;
      overflow_total <= ld_ovf;
    end
  end

endmodule

// ===== src/line_assembler_with_overflow_discard.sv =====
`timescale 1ns / 1ps
`include "line_assembler_with_overflow_discard_defines.svh"
// Newline framer for a received serial byte stream. Each byte is classified
// by the front end as it is taken in (carriage returns and bytes inside an
// overflow discard are dropped with no result); a two-entry command queue
// sits between it and the back end, so bytes keep coming in at one per
// cycle until the queue fills. A stored character is one write into the
// 64-byte line store. A newline that ends a line of n characters starts a
// drain of the store: it has one registered read port, so the characters
// stream out one per cycle, slowed only by stall on the output. Counter
// values on every result are those after the byte that caused it; both
// counters saturate.
module line_assembler_with_overflow_discard import lafd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [7:0]  line_char,
  output logic        run_last,
  output logic [31:0] line_total,
  output logic [31:0] overflow_total
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  lafd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  lafd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  lafd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_kind     (event_kind),
    .line_char      (line_char),
    .run_last       (run_last),
    .line_total     (line_total),
    .overflow_total (overflow_total)
  );

  // empty-line and overflow results stand alone and carry no character
  `LAFD_ASSERT_IMP(a_nonchar_single, out_valid && event_kind != KIND_CHAR, run_last && line_char == 8'd0)
  // counters seen on consecutive results never go backwards
  `LAFD_ASSERT_IMP(a_line_mono, (out_valid && !out_stall) ##1 out_valid, line_total >= $past(line_total))
  `LAFD_ASSERT_IMP(a_ovf_mono, (out_valid && !out_stall) ##1 out_valid, overflow_total >= $past(overflow_total))
  // a command is never pushed into a full queue
  `LAFD_ASSERT_NEXT(a_queue_safe, q_full && !q_pop, !push || q_full)

endmodule

// ===== tb/sv/line_assembler_with_overflow_discard_tb.sv =====
`timescale 1ns / 1ps
module line_assembler_with_overflow_discard_tb;
  import lafd_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 100;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 100;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic        last;
    logic [31:0] lines;
    logic [31:0] ovfs;
  } line_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_kind;
  logic [7:0]  line_char;
  logic        run_last;
  logic [31:0] line_total;
  logic [31:0] overflow_total;

  line_assembler_with_overflow_discard dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_kind     (event_kind),
    .line_char      (line_char),
    .run_last       (run_last),
    .line_total     (line_total),
    .overflow_total (overflow_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  line_buf [0:LINE_MAX-1];
  int          fill_cnt = 0;
  logic        discarding = 1'b0;
  logic [31:0] lines_done = '0;
  logic [31:0] overflows = '0;
  int          useful_bytes = 0;

  line_event_t pending_events [$];
  int          fail_count = 0;
  int          cycle_count = 0;

  // sender pacing
  int          tx_burst_left = 0;
  bit          tx_gappy = 1'b1;

  // receiver pacing
  bit          rx_hold_req = 1'b0;
  int          rx_hold_left = 0;
  int          rx_mode_left = 0;
  int          rx_period = 2;
  rx_pattern_t rx_mode = RX_FREE;

  function automatic void push_event(input logic [1:0] kind, input logic [7:0] ch,
                                     input logic last);
    line_event_t ev;
    ev.kind  = kind;
    ev.ch    = ch;
    ev.last  = last;
    ev.lines = lines_done;
    ev.ovfs  = overflows;
    pending_events.push_back(ev);
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    if (b == CH_NL) begin
      useful_bytes++;
      if (discarding) begin
        discarding = 1'b0;
        fill_cnt = 0;
      end else begin
        if (lines_done != '1) lines_done = lines_done + 32'd1;
        if (fill_cnt == 0) begin
          push_event(KIND_EMPTY, 8'h00, 1'b1);
        end else begin
          for (int i = 0; i < fill_cnt; i++)
            push_event(KIND_CHAR, line_buf[i], i == fill_cnt - 1);
        end
        fill_cnt = 0;
      end
    end else if (b != CH_CR && !discarding) begin
      useful_bytes++;
      if (fill_cnt + 1 < LINE_MAX) begin
        line_buf[fill_cnt] = b;
        fill_cnt++;
      end else begin
        // full store: line dropped, byte dropped, discard until newline
        fill_cnt = 0;
        discarding = 1'b1;
        if (overflows != '1) overflows = overflows + 32'd1;
        push_event(KIND_OVERFLOW, 8'h00, 1'b1);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 16);
      gap = tx_gappy ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tx_burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    predict_byte(b);
  endtask

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_NL || c == CH_CR);
    return c;
  endfunction

  task automatic send_chars(input int n);
    for (int i = 0; i < n; i++) send_byte(rand_char());
  endtask

  task automatic hold_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // receiver: own stall pattern, plus a long hold on request
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = LONG_HOLD;
      rx_hold_req = 1'b0;
    end
    if (rx_mode_left == 0) begin
      rx_mode = rx_pattern_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 256);
      rx_period = $urandom_range(2, 7);
    end else begin
      rx_mode_left--;
    end
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ((rx_mode_left % rx_period) == 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    line_event_t ev;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected transaction: kind %0d char %0h last %0d lines %0d ovf %0d",
                 $time, event_kind, line_char, run_last, line_total, overflow_total);
        fail_count++;
      end else begin
        ev = pending_events.pop_front();
        check_field("event_kind", 32'(ev.kind), 32'(event_kind));
        check_field("line_char", 32'(ev.ch), 32'(line_char));
        check_field("run_last", 32'(ev.last), 32'(run_last));
        check_field("line_total", ev.lines, line_total);
        check_field("overflow_total", ev.ovfs, overflow_total);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d transactions outstanding", $time, pending_events.size());
      $display("line_assembler_with_overflow_discard test failed");
      $finish;
    end
  end

  // short lines, empty lines, CR handling, byte extremes
  task automatic test_basic_lines();
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte(CH_NL);
    send_byte(CH_NL);
    send_byte(CH_CR);
    send_byte(CH_NL);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_CR);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(CH_CR);
    send_byte(CH_NL);
  endtask

  // longest line that fits; CR into a full store is still dropped
  task automatic test_max_line();
    send_chars(LINE_MAX - 1);
    send_byte(CH_CR);
    send_byte(CH_NL);
  endtask

  task automatic test_overflow();
    send_chars(LINE_MAX - 1);
    send_byte(8'h00);
    send_byte(8'h61);
    send_byte(CH_CR);
    send_byte(8'hFF);
    send_byte(CH_NL);
    send_byte(CH_NL);
    send_byte(8'h78);
    send_byte(CH_NL);
    // overflow followed straight by the newline that ends the discard
    send_chars(LINE_MAX);
    send_byte(CH_NL);
    send_byte(8'h00);
    send_byte(CH_NL);
  endtask

  // receiver holds off while the sender keeps offering, so input stalls
  task automatic test_backpressure();
    tx_gappy = 1'b0;
    hold_input();
    rx_hold_req = 1'b1;
    @(posedge clk);
    for (int k = 0; k < 6; k++) begin
      send_chars($urandom_range(3, 12));
      send_byte(CH_NL);
    end
    send_byte(CH_NL);
    hold_input();
    wait_drained();
    tx_gappy = 1'b1;
  endtask

  task automatic test_random();
    int goal;
    int len;
    int r;
    goal = useful_bytes + RANDOM_BYTES;
    while (useful_bytes < goal) begin
      tx_gappy = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, 12);
        else if (r < 90) len = $urandom_range(13, LINE_MAX - 2);
        else if (r < 96) len = LINE_MAX - 1;
        else len = $urandom_range(LINE_MAX, LINE_MAX + 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 15) == 0) send_byte(CH_CR);
          send_byte(rand_char());
        end
        if ($urandom_range(0, 3) == 0) send_byte(CH_CR);
        // a few lines are left unterminated and run into the next one
        if ($urandom_range(0, 19) != 0) send_byte(CH_NL);
      end
      if ($urandom_range(0, 24) == 0) begin
        hold_input();
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_basic_lines();
    test_max_line();
    test_overflow();
    test_backpressure();
    test_random();
    hold_input();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("line_assembler_with_overflow_discard test passed");
    end else begin
      $display("line_assembler_with_overflow_discard test failed");
    end
    $finish;
  end

endmodule
